FILE: design/alpha_layer_composite_to_palette_assert.svh
// ---------------------------------------------------------------------------
// Alpha layer compositor assertion macros
// Shared property forms for the compositor checks.
// ---------------------------------------------------------------------------
`ifndef ALPHA_LAYER_COMPOSITE_TO_PALETTE_ASSERT_SVH
`define ALPHA_LAYER_COMPOSITE_TO_PALETTE_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define ALC_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("compositor check failed in the same cycle");

// The condition implies the consequence in the next cycle.
`define ALC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("compositor check failed in the next cycle");

`endif

FILE: design/alc_pkg.sv
// ---------------------------------------------------------------------------
// Alpha layer compositor package
// Command and status types, operand selects and palette constants.
// ---------------------------------------------------------------------------
package alc_pkg;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2,
        SEL_TRANS = 2'd3
    } chan_sel_t;

    typedef struct packed {
        logic      capture;
        logic      issue;
        chan_sel_t sel;
        logic      load_out;
    } cmd_t;

    typedef struct packed {
        logic live;
    } status_t;

    localparam logic [2:0] ISSUE_COUNT = 3'd4;
    localparam logic [2:0] STEP_LAST   = 3'd6;

    localparam logic [7:0]  ALPHA_MAX    = 8'd255;
    localparam logic [14:0] CUTOFF_SCALE = 15'd30000;

    localparam logic [7:0] LVL_TOP = 8'd255;
    localparam logic [7:0] LVL_4   = 8'd215;
    localparam logic [7:0] LVL_3   = 8'd175;
    localparam logic [7:0] LVL_2   = 8'd135;
    localparam logic [7:0] LVL_1   = 8'd95;

    localparam logic [7:0] CUBE_BASE = 8'd16;
    localparam logic [7:0] CUBE_R    = 8'd36;
    localparam logic [7:0] CUBE_G    = 8'd6;

    function automatic logic [2:0] level_of(input logic [7:0] v);
        logic [2:0] lvl;
        if (v == LVL_TOP)
            lvl = 3'd5;
        else if (v >= LVL_4)
            lvl = 3'd4;
        else if (v >= LVL_3)
            lvl = 3'd3;
        else if (v >= LVL_2)
            lvl = 3'd2;
        else if (v >= LVL_1)
            lvl = 3'd1;
        else
            lvl = 3'd0;
        return lvl;
    endfunction

endpackage

FILE: design/alc_controller.sv
// ---------------------------------------------------------------------------
// Alpha layer compositor controller
// Sequences the four shared products of a layer and the result hand-off.
// ---------------------------------------------------------------------------
module alc_controller
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            last_layer,
    output logic            out_valid,
    input  logic            out_stall,
    input  alc_pkg::status_t status,
    output alc_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_EMIT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       last_reg;
    logic       last_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        last_next    = last_reg;
        cmd.capture  = 1'b0;
        cmd.issue    = 1'b0;
        cmd.sel      = alc_pkg::SEL_RED;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    last_next   = last_layer;
                    if (status.live)
                    begin
                        state_next = S_RUN;
                        step_next  = 3'd0;
                    end
                    else if (last_layer)
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_RUN:
            begin
                cmd.issue = (step_reg < alc_pkg::ISSUE_COUNT);
                cmd.sel   = alc_pkg::chan_sel_t'(step_reg[1:0]);
                step_next = step_reg + 3'd1;
                if (step_reg == alc_pkg::STEP_LAST)
                    state_next = last_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: design/alc_datapath.sv
// ---------------------------------------------------------------------------
// Alpha layer compositor datapath
// Shared multiplier, divide by 255, sums, transmittance, palette.
// ---------------------------------------------------------------------------
module alc_datapath
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       red,
    input  logic [7:0]       green,
    input  logic [7:0]       blue,
    input  logic [7:0]       alpha,
    input  alc_pkg::cmd_t    cmd,
    output alc_pkg::status_t status,
    output logic [7:0]       palette_index
);

    localparam int TW    = FRAC_BITS + 1;
    localparam int SW    = FRAC_BITS + 8;
    localparam int PW    = 16 + TW;
    localparam int NTERM = (PW + 7) / 8;
    localparam int CW    = TW + 15;

    localparam logic [TW-1:0] T_ONE   = TW'(1) << FRAC_BITS;
    localparam logic [SW:0]   SUM_MAX = (SW + 1)'(255) << FRAC_BITS;

    logic [15:0]         prod_r_reg;
    logic [15:0]         prod_g_reg;
    logic [15:0]         prod_b_reg;
    logic [7:0]          clear_reg;

    logic [SW-1:0]       red_sum_reg;
    logic [SW-1:0]       red_sum_next;
    logic [SW-1:0]       green_sum_reg;
    logic [SW-1:0]       green_sum_next;
    logic [SW-1:0]       blue_sum_reg;
    logic [SW-1:0]       blue_sum_next;
    logic [TW-1:0]       trans_reg;
    logic [TW-1:0]       trans_next;

    logic [15:0]         opnd;
    logic [PW-1:0]       mul_reg;
    logic [PW-1:0]       mul_q_reg;
    logic [PW-1:0]       qest_sum;
    logic [PW-1:0]       qest_reg;
    logic [PW-1:0]       rem_full;
    logic [11:0]         rem;
    logic [11:0]         corr;
    logic [PW-1:0]       quot_full;
    logic [SW-1:0]       quot_reg;

    logic                v1_reg;
    logic                v2_reg;
    logic                v3_reg;
    alc_pkg::chan_sel_t  sel1_reg;
    alc_pkg::chan_sel_t  sel2_reg;
    alc_pkg::chan_sel_t  sel3_reg;

    logic [CW-1:0]       cut_prod;
    logic [2:0]          lvl_r;
    logic [2:0]          lvl_g;
    logic [2:0]          lvl_b;
    logic [7:0]          index_next;
    logic [7:0]          palette_index_reg;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] s,
                                              input logic [SW-1:0] q);
        logic [SW:0] t;
        t = {1'b0, s} + {1'b0, q};
        return (t > SUM_MAX) ? SUM_MAX[SW-1:0] : t[SW-1:0];
    endfunction

    assign cut_prod    = CW'(trans_reg) * CW'(alc_pkg::CUTOFF_SCALE);
    assign status.live = (cut_prod > CW'(T_ONE));

    always_comb
    begin
        case (cmd.sel)
            alc_pkg::SEL_RED:   opnd = prod_r_reg;
            alc_pkg::SEL_GREEN: opnd = prod_g_reg;
            alc_pkg::SEL_BLUE:  opnd = prod_b_reg;
            alc_pkg::SEL_TRANS: opnd = {8'd0, clear_reg};
            default:            opnd = prod_r_reg;
        endcase
    end

    always_comb
    begin
        qest_sum = '0;
        for (int i = 1; i <= NTERM; i++)
            qest_sum = qest_sum + (mul_reg >> (8 * i));
    end

    assign rem_full  = mul_q_reg - (qest_reg << 8) + qest_reg;
    assign rem       = rem_full[11:0];
    assign corr      = (rem + 12'd1 + (rem >> 8)) >> 8;
    assign quot_full = qest_reg + PW'(corr);

    always_comb
    begin
        red_sum_next   = red_sum_reg;
        green_sum_next = green_sum_reg;
        blue_sum_next  = blue_sum_reg;
        trans_next     = trans_reg;
        if (cmd.load_out)
        begin
            red_sum_next   = '0;
            green_sum_next = '0;
            blue_sum_next  = '0;
            trans_next     = T_ONE;
        end
        else if (v3_reg)
        begin
            case (sel3_reg)
                alc_pkg::SEL_RED:   red_sum_next   = sat_add(red_sum_reg, quot_reg);
                alc_pkg::SEL_GREEN: green_sum_next = sat_add(green_sum_reg, quot_reg);
                alc_pkg::SEL_BLUE:  blue_sum_next  = sat_add(blue_sum_reg, quot_reg);
                alc_pkg::SEL_TRANS: trans_next     = quot_reg[TW-1:0];
                default:            trans_next     = trans_reg;
            endcase
        end
    end

    assign lvl_r      = alc_pkg::level_of(red_sum_reg[SW-1:FRAC_BITS]);
    assign lvl_g      = alc_pkg::level_of(green_sum_reg[SW-1:FRAC_BITS]);
    assign lvl_b      = alc_pkg::level_of(blue_sum_reg[SW-1:FRAC_BITS]);
    assign index_next = alc_pkg::CUBE_BASE + alc_pkg::CUBE_R * {5'd0, lvl_r}
                        + alc_pkg::CUBE_G * {5'd0, lvl_g} + {5'd0, lvl_b};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_sum_reg   <= '0;
            green_sum_reg <= '0;
            blue_sum_reg  <= '0;
            trans_reg     <= T_ONE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            sel1_reg      <= alc_pkg::SEL_RED;
            sel2_reg      <= alc_pkg::SEL_RED;
            sel3_reg      <= alc_pkg::SEL_RED;
        end
        else
        begin
            red_sum_reg   <= red_sum_next;
            green_sum_reg <= green_sum_next;
            blue_sum_reg  <= blue_sum_next;
            trans_reg     <= trans_next;
            v1_reg        <= cmd.issue;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            sel1_reg      <= cmd.sel;
            sel2_reg      <= sel1_reg;
            sel3_reg      <= sel2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            prod_r_reg <= red * alpha;
            prod_g_reg <= green * alpha;
            prod_b_reg <= blue * alpha;
            clear_reg  <= alc_pkg::ALPHA_MAX - alpha;
        end
        mul_reg   <= PW'(opnd) * PW'(trans_reg);
        mul_q_reg <= mul_reg;
        qest_reg  <= qest_sum;
        quot_reg  <= quot_full[SW-1:0];
        if (cmd.load_out)
            palette_index_reg <= index_next;
    end

    assign palette_index = palette_index_reg;

endmodule

FILE: design/alpha_layer_composite_to_palette.sv
// ---------------------------------------------------------------------------
// Alpha layer compositor to 256-color palette
// Front-to-back RGBA compositing of one cell's layers into a cube index.
// ---------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in       in_valid / in_stall    red, green, blue, alpha, last_layer
//  out      out_valid / out_stall  palette_index
//
// A contributing layer stalls the input until its four products, which share
// one multiplier and each pass a divide by 255, are summed. A layer past the
// transmittance cutoff stalls nothing unless it is its cell's last. The last
// layer of a cell then passes an emit state that loads the output register.
// Reset clears the sums, sets transmittance to one and empties the output.
// A stalled output only holds the block once the next result is ready.
// ---------------------------------------------------------------------------
`include "alpha_layer_composite_to_palette_assert.svh"

module alpha_layer_composite_to_palette
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       last_layer,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] palette_index
);

    alc_pkg::cmd_t    cmd;
    alc_pkg::status_t status;

    alc_controller u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_layer (last_layer),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .cmd        (cmd)
    );

    alc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .cmd           (cmd),
        .status        (status),
        .palette_index (palette_index)
    );

    `ALC_ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.load_out, out_valid)
    `ALC_ASSERT_SAME(a_issue_holds_input, clk, rst_n, cmd.issue, in_stall)
    `ALC_ASSERT_SAME(a_load_not_while_idle, clk, rst_n, cmd.load_out, in_stall && !cmd.capture)
    `ALC_ASSERT_NEXT(a_live_capture_busy, clk, rst_n, cmd.capture && status.live, in_stall)

endmodule
